// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the tlb rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tlb assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlb assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlb assertion failed");

`endif

// ----- hw/rtl/tlbl_pkg.sv -----
// ----------------------------------------------------------------------------
// tlbl_pkg
// types, constants and helpers shared by the tlb lookup rtl
// ----------------------------------------------------------------------------
`default_nettype none

package tlbl_pkg;

  localparam int unsigned TLB_ENTRIES  = 16;
  localparam int unsigned OFFSET_WIDTH = 8;
  localparam int unsigned PAGE_WIDTH   = 8;
  localparam int unsigned FRAME_WIDTH  = 8;
  localparam int unsigned AGE_WIDTH    = 16;
  localparam int unsigned ADDR_WIDTH   = 16;
  localparam int unsigned IDX_WIDTH    = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  typedef logic [TLB_ENTRIES-1:0]  entry_vec_t;
  typedef logic [PAGE_WIDTH-1:0]   page_t;
  typedef logic [FRAME_WIDTH-1:0]  frame_t;
  typedef logic [OFFSET_WIDTH-1:0] page_ofs_t;
  typedef logic [AGE_WIDTH-1:0]    age_t;
  typedef logic [IDX_WIDTH-1:0]    idx_t;
  typedef logic [ADDR_WIDTH-1:0]   addr_t;

  localparam age_t AGE_MAX  = '1;
  localparam age_t AGE_NEAR = AGE_MAX - age_t'(1);
  localparam idx_t IDX_LAST = idx_t'(TLB_ENTRIES - 1);

  typedef enum logic [0:0] {
    OP_LOOKUP = 1'b0,
    OP_FILL   = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    POLICY_FIFO = 1'b0,
    POLICY_LRU  = 1'b1
  } policy_e;

  // register index, taken from the word address bit
  typedef enum logic [0:0] {
    REG_POLICY = 1'b0
  } reg_idx_e;

  typedef struct packed {
    op_e    operation;
    addr_t  logical_address;
    frame_t fill_frame;
  } req_t;

  typedef struct packed {
    logic   hit;
    frame_t frame_number;
    addr_t  phys_addr;
  } rsp_t;

  // command from the control path to the entry array
  typedef struct packed {
    logic       lookup;
    logic       fill;
    entry_vec_t fill_sel;
    page_t      page;
    frame_t     frame;
  } cam_cmd_t;

  // status from the entry array
  typedef struct packed {
    logic       hit;
    entry_vec_t hit_sel;
    frame_t     hit_frame;
    entry_vec_t valid;
    entry_vec_t age_zero;
    entry_vec_t age_near_max;
  } cam_stat_t;

  // update command for the age order tracker
  typedef struct packed {
    logic       lookup;
    logic       fill;
    logic       all_valid;
    entry_vec_t hit_sel;
    entry_vec_t fill_sel;
    entry_vec_t age_zero;
    entry_vec_t age_near_max;
  } lru_cmd_t;

  // isolate the lowest set bit
  function automatic entry_vec_t lowest_one(entry_vec_t v);
    return v & (~v + entry_vec_t'(1));
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tlbl_if.sv -----
// ----------------------------------------------------------------------------
// tlbl_if
// valid/ready channels for lookup requests and results
// ----------------------------------------------------------------------------
`default_nettype none

interface tlbl_req_if;
  import tlbl_pkg::*;
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tlbl_rsp_if;
  import tlbl_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tlbl_cfg.sv -----
// ----------------------------------------------------------------------------
// tlbl_cfg
// apb register file holding the replacement policy
// ----------------------------------------------------------------------------
`default_nettype none

module tlbl_cfg import tlbl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output logic [APB_DATA_W-1:0] prdata_o,
  output logic                  pready_o,
  output policy_e               policy_o
);

  policy_e  policy_q, policy_d;
  reg_idx_e reg_idx;
  logic     wr_en;

  assign pready_o = 1'b1;
  assign reg_idx  = reg_idx_e'(paddr_i[APB_ADDR_W-1]);
  assign wr_en    = psel_i & penable_i & pwrite_i;

  always_comb begin
    policy_d = policy_q;
    prdata_o = '0;
    case (reg_idx)
      REG_POLICY: begin
        prdata_o = APB_DATA_W'(policy_q);
        if (wr_en) begin
          policy_d = policy_e'(pwdata_i[0]);
        end
      end
      default: begin
        prdata_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_FIFO;
    end else begin
      policy_q <= policy_d;
    end
  end

  assign policy_o = policy_q;

endmodule

`default_nettype wire

// ----- hw/rtl/tlbl_cam.sv -----
// ----------------------------------------------------------------------------
// tlbl_cam
// entry array with parallel page match and per-entry saturating ages
// ----------------------------------------------------------------------------
`default_nettype none

module tlbl_cam import tlbl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  cam_cmd_t  cmd_i,
  output cam_stat_t stat_o
);

  page_t      page_q  [TLB_ENTRIES];
  frame_t     frame_q [TLB_ENTRIES];
  entry_vec_t valid_q, valid_d;
  age_t       age_q   [TLB_ENTRIES];
  age_t       age_d   [TLB_ENTRIES];
  entry_vec_t match;
  entry_vec_t hit_sel;
  frame_t     hit_frame;
  entry_vec_t age_zero;
  entry_vec_t age_near;

  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match[i]    = valid_q[i] & (page_q[i] == cmd_i.page);
      age_zero[i] = (age_q[i] == '0);
      age_near[i] = (age_q[i] == AGE_NEAR);
    end
  end

  // lowest matching slot wins on duplicates
  assign hit_sel = lowest_one(match);

  always_comb begin
    hit_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      hit_frame = hit_frame | (frame_q[i] & {FRAME_WIDTH{hit_sel[i]}});
    end
  end

  assign stat_o.hit          = |match;
  assign stat_o.hit_sel      = hit_sel;
  assign stat_o.hit_frame    = hit_frame;
  assign stat_o.valid        = valid_q;
  assign stat_o.age_zero     = age_zero;
  assign stat_o.age_near_max = age_near;

  always_comb begin
    valid_d = valid_q | (cmd_i.fill ? cmd_i.fill_sel : '0);
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      age_d[i] = age_q[i];
      if (cmd_i.lookup) begin
        if (hit_sel[i]) begin
          age_d[i] = '0;
        end else if (age_q[i] != AGE_MAX) begin
          age_d[i] = age_q[i] + age_t'(1);
        end
      end else if (cmd_i.fill && cmd_i.fill_sel[i]) begin
        age_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else if (en_i) begin
      valid_q <= valid_d;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        age_q[i] <= age_d[i];
      end
    end
  end

  // tag and frame storage, no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (en_i && cmd_i.fill && cmd_i.fill_sel[i]) begin
        page_q[i]  <= cmd_i.page;
        frame_q[i] <= cmd_i.frame;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tlbl_lru.sv -----
// ----------------------------------------------------------------------------
// tlbl_lru
// victim selection: fifo pointer and a pairwise age order matrix
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tlbl_lru import tlbl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  policy_e    policy_i,
  input  lru_cmd_t   cmd_i,
  output entry_vec_t victim_o
);

  // ge_q[i][j] is set when age of entry i >= age of entry j
  entry_vec_t ge_q [TLB_ENTRIES];
  entry_vec_t ge_d [TLB_ENTRIES];
  idx_t       ptr_q, ptr_d;
  logic       advance;
  entry_vec_t lru_sel;
  entry_vec_t fifo_sel;
  logic       order_total;

  assign advance = cmd_i.fill & cmd_i.all_valid & (policy_i == POLICY_FIFO);
  assign ptr_d   = (ptr_q == IDX_LAST) ? '0 : ptr_q + idx_t'(1);

  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      for (int j = 0; j < TLB_ENTRIES; j++) begin
        if (i == j) begin
          ge_d[i][j] = 1'b1;
        end else if ((cmd_i.lookup && cmd_i.hit_sel[j]) ||
                     (cmd_i.fill && cmd_i.fill_sel[j])) begin
          ge_d[i][j] = 1'b1;
        end else if (cmd_i.lookup && cmd_i.hit_sel[i]) begin
          ge_d[i][j] = 1'b0;
        end else if (cmd_i.fill && cmd_i.fill_sel[i]) begin
          ge_d[i][j] = cmd_i.age_zero[j];
        end else if (cmd_i.lookup) begin
          // saturation can only turn a strict less into equal
          ge_d[i][j] = ge_q[i][j] | cmd_i.age_near_max[i];
        end else begin
          ge_d[i][j] = ge_q[i][j];
        end
      end
    end
  end

  // oldest entry, lowest index on ties
  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      lru_sel[i] = 1'b1;
      for (int j = 0; j < TLB_ENTRIES; j++) begin
        if (j < i) begin
          lru_sel[i] = lru_sel[i] & ~ge_q[j][i];
        end else if (j > i) begin
          lru_sel[i] = lru_sel[i] & ge_q[i][j];
        end
      end
    end
  end

  assign fifo_sel = entry_vec_t'(1) << ptr_q;
  assign victim_o = (policy_i == POLICY_LRU) ? lru_sel : fifo_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        ge_q[i] <= '1;
      end
    end else if (en_i) begin
      if (advance) begin
        ptr_q <= ptr_d;
      end
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        ge_q[i] <= ge_d[i];
      end
    end
  end

  always_comb begin
    order_total = 1'b1;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      for (int j = 0; j < TLB_ENTRIES; j++) begin
        order_total = order_total & (ge_q[i][j] | ge_q[j][i]);
      end
    end
  end

  `ASSERT_ALWAYS(a_lru_onehot, clk_i, rst_ni, $onehot(lru_sel))
  `ASSERT_ALWAYS(a_order_total, clk_i, rst_ni, order_total)
  `ASSERT_IMPLIES(a_ptr_moves, clk_i, rst_ni, !$stable(ptr_q), $past(en_i && advance))

endmodule

`default_nettype wire

// ----- hw/rtl/tlb_lookup_fifo_lru.sv -----
// ----------------------------------------------------------------------------
// tlb_lookup_fifo_lru
// 16-entry fully associative tlb with fifo or lru replacement
// ----------------------------------------------------------------------------
// One request beat is taken per clock while results drain, and each
// produces exactly one result beat. A beat lands in the input register;
// once the output register is free or being drained, the page is compared
// against all entries in parallel, ages and the victim order are updated,
// and the result is captured in the output register. The lru victim comes
// from a registered pairwise age order, so the fill path never searches the
// ages. Lookups age all entries and clear the age of the hit entry; fills
// write the first free slot, otherwise the fifo or lru victim. A result
// still waiting on the output stalls processing; the input register can
// still take one more beat, then ready drops until the result drains. No
// clearing pass after reset: the block is ready at once. The policy
// register sits at byte address 0 of the apb port.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tlb_lookup_fifo_lru import tlbl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tlbl_req_if.sink              req_i,
  tlbl_rsp_if.source            rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  policy_e    policy;

  // input stage
  logic       in_vld_q, in_vld_d;
  req_t       in_q;
  logic       accept;

  // output stage
  logic       out_vld_q, out_vld_d;
  rsp_t       out_q, out_d;

  // processing fires when the input register holds a beat and
  // the output register is free or being drained
  logic       go;

  cam_cmd_t   cam_cmd;
  cam_stat_t  cam_stat;
  lru_cmd_t   lru_cmd;
  entry_vec_t victim;
  entry_vec_t free_sel;
  entry_vec_t fill_sel;
  logic       is_fill;
  logic       is_lookup;
  page_t      page;
  page_ofs_t  offset;

  tlbl_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .policy_o  (policy)
  );

  // handshake
  assign go          = in_vld_q & (~out_vld_q | rsp_o.ready);
  assign req_i.ready = ~in_vld_q | go;
  assign accept      = req_i.valid & req_i.ready;
  assign in_vld_d    = accept ? 1'b1 : (go ? 1'b0 : in_vld_q);
  assign out_vld_d   = go ? 1'b1 : (rsp_o.ready ? 1'b0 : out_vld_q);

  // address split
  assign page      = page_t'(in_q.logical_address >> OFFSET_WIDTH);
  assign offset    = in_q.logical_address[OFFSET_WIDTH-1:0];
  assign is_fill   = go & (in_q.operation == OP_FILL);
  assign is_lookup = go & (in_q.operation == OP_LOOKUP);

  // slot choice for a fill: first free slot, else the victim
  assign free_sel = lowest_one(~cam_stat.valid);
  assign fill_sel = (&cam_stat.valid) ? victim : free_sel;

  assign cam_cmd.lookup   = is_lookup;
  assign cam_cmd.fill     = is_fill;
  assign cam_cmd.fill_sel = fill_sel;
  assign cam_cmd.page     = page;
  assign cam_cmd.frame    = in_q.fill_frame;

  tlbl_cam u_cam (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (go),
    .cmd_i  (cam_cmd),
    .stat_o (cam_stat)
  );

  assign lru_cmd.lookup       = is_lookup;
  assign lru_cmd.fill         = is_fill;
  assign lru_cmd.all_valid    = &cam_stat.valid;
  assign lru_cmd.hit_sel      = cam_stat.hit_sel;
  assign lru_cmd.fill_sel     = fill_sel;
  assign lru_cmd.age_zero     = cam_stat.age_zero;
  assign lru_cmd.age_near_max = cam_stat.age_near_max;

  tlbl_lru u_lru (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (go),
    .policy_i (policy),
    .cmd_i    (lru_cmd),
    .victim_o (victim)
  );

  // result: translation on a lookup hit, all zero otherwise
  always_comb begin
    out_d = '0;
    if ((in_q.operation == OP_LOOKUP) && cam_stat.hit) begin
      out_d.hit          = 1'b1;
      out_d.frame_number = cam_stat.hit_frame;
      out_d.phys_addr    = addr_t'({cam_stat.hit_frame, offset});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= req_i.data;
    end
    if (go) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

  `ASSERT_IMPLIES(a_fill_one_slot, clk_i, rst_ni, is_fill, $onehot(fill_sel))
  `ASSERT_NEXT(a_result_follows, clk_i, rst_ni, go, out_vld_q)

endmodule

`default_nettype wire

// ----- tb/tlb_lookup_fifo_lru_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tlb_lookup_fifo_lru_tb
// self-checking bench for the fully associative tlb with fifo/lru victims.
// request beats are predicted on acceptance by a model of the entry array
// and every result beat is checked in order. a directed pass covers empty,
// full, duplicate and replacement cases. a stretch with no idling runs a
// train of misses that ages every entry before an lru replacement. random
// phases with a small page pool then follow, switching the replacement
// policy between phases.
// ----------------------------------------------------------------------------
module tlb_lookup_fifo_lru_tb;
  import tlbl_pkg::*;

  localparam int unsigned REG_STRIDE     = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned IDLE_PERCENT   = 21;
  localparam int unsigned RANDOM_PHASES  = 7;
  localparam int unsigned PHASE_ITEMS    = 146;
  localparam int unsigned POOL_SIZE      = 12;
  localparam int unsigned STEADY_ITEMS   = 240;

  // model of the entry array plus the in-order store of expected results
  class translation_scoreboard;
    page_t   slot_page [TLB_ENTRIES];
    frame_t  slot_frame[TLB_ENTRIES];
    logic    slot_valid[TLB_ENTRIES];
    age_t    slot_age  [TLB_ENTRIES];
    idx_t    fifo_ptr;
    policy_e policy;
    rsp_t    pending_translations[$];
    int      errors;

    function new();
      foreach (slot_valid[i]) begin
        slot_page[i]  = '0;
        slot_frame[i] = '0;
        slot_valid[i] = 1'b0;
        slot_age[i]   = '0;
      end
      fifo_ptr = '0;
      policy   = POLICY_FIFO;
      errors   = 0;
    endfunction

    // only the policy register exists, and only its low bit counts
    function void write_register(int unsigned index, logic [APB_DATA_W-1:0] value);
      if (index == REG_POLICY) begin
        policy = policy_e'(value[0]);
      end
    endfunction

    function rsp_t predict_translation(req_t beat);
      rsp_t      res;
      page_t     pg;
      page_ofs_t off;
      int        slot;
      res  = '0;
      pg   = beat.logical_address[ADDR_WIDTH-1 -: PAGE_WIDTH];
      off  = beat.logical_address[OFFSET_WIDTH-1:0];
      slot = -1;
      if (beat.operation == OP_FILL) begin
        // first free slot wins, victim only when the array is full
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (!slot_valid[i] && slot < 0) begin
            slot = i;
          end
        end
        if (slot < 0) begin
          if (policy == POLICY_FIFO) begin
            slot     = fifo_ptr;
            fifo_ptr = (fifo_ptr == IDX_LAST) ? idx_t'(0) : idx_t'(fifo_ptr + 1);
          end else begin
            slot = 0;
            for (int i = 1; i < TLB_ENTRIES; i++) begin
              if (slot_age[i] > slot_age[slot]) begin
                slot = i;
              end
            end
          end
        end
        slot_page[slot]  = pg;
        slot_frame[slot] = beat.fill_frame;
        slot_valid[slot] = 1'b1;
        slot_age[slot]   = '0;
      end else begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (slot_age[i] != AGE_MAX) begin
            slot_age[i] = slot_age[i] + age_t'(1);
          end
        end
        // lowest matching slot answers when pages are duplicated
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (slot_valid[i] && slot_page[i] == pg && !res.hit) begin
            slot_age[i]      = '0;
            res.hit          = 1'b1;
            res.frame_number = slot_frame[i];
            res.phys_addr    = addr_t'({slot_frame[i], off});
          end
        end
      end
      return res;
    endfunction

    function void note_request(req_t beat);
      pending_translations.insert(pending_translations.size(), predict_translation(beat));
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_translations.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_translations.pop_front();
      if (got.hit !== want.hit) begin
        $display("%0t: hit mismatch, expected %0d actual %0d", $time, want.hit, got.hit);
        errors++;
      end
      if (got.frame_number !== want.frame_number) begin
        $display("%0t: frame_number mismatch, expected %h actual %h",
                 $time, want.frame_number, got.frame_number);
        errors++;
      end
      if (got.phys_addr !== want.phys_addr) begin
        $display("%0t: phys_addr mismatch, expected %h actual %h",
                 $time, want.phys_addr, got.phys_addr);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tlbl_req_if req_if ();
  tlbl_rsp_if rsp_if ();

  translation_scoreboard sb;

  // random idling on both sides; cleared for the steady stretch
  bit          idle_en;
  int unsigned stall_cycles;
  page_t       page_pool[POOL_SIZE];

  tlb_lookup_fifo_lru dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk_i = ~clk_i;

  // result side back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    rsp_if.ready <= !idle_en || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // monitor: values seen here are the ones that held before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        sb.note_request(req_if.data);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_result(rsp_if.data);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL tlb_lookup_fifo_lru");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one request beat; valid stays high into the next call unless it idles
  task automatic send_request(op_e op, addr_t la, frame_t ff);
    req_t beat;
    beat.operation       = op;
    beat.logical_address = la;
    beat.fill_frame      = ff;
    while (idle_en && $urandom_range(99) < IDLE_PERCENT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= beat;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // stop sending and wait until every expected result has come back
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_translations.size() != 0);
  endtask

  task automatic apb_access(logic wr, logic [APB_ADDR_W-1:0] addr,
                            logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // register write while the block is idle, then read the policy back
  task automatic write_register(int unsigned index, logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] rdata;
    wait_drained();
    apb_access(1'b1, APB_ADDR_W'(REG_STRIDE * index), value, rdata);
    sb.write_register(index, value);
    // bus returns to idle between the two transfers
    @(posedge clk_i);
    apb_access(1'b0, APB_ADDR_W'(REG_STRIDE * REG_POLICY), '0, rdata);
    if (rdata !== APB_DATA_W'(sb.policy)) begin
      $display("%0t: policy readback mismatch, expected %h actual %h",
               $time, APB_DATA_W'(sb.policy), rdata);
      sb.errors++;
    end
  endtask

  task automatic run_directed();
    // lookups into an empty array miss, with all-zero and all-one addresses
    send_request(OP_LOOKUP, 16'h0000, 8'hFF);
    send_request(OP_LOOKUP, 16'hFFFF, 8'h00);
    // extreme pages and frames, then hits on both
    send_request(OP_FILL, 16'h00AA, 8'hFF);
    send_request(OP_FILL, 16'hFF55, 8'h00);
    send_request(OP_LOOKUP, 16'h00FF, 8'h00);
    send_request(OP_LOOKUP, 16'hFF00, 8'hFF);
    // duplicate page: lookup must still answer from the lower slot
    send_request(OP_FILL, 16'h0000, 8'h5A);
    send_request(OP_LOOKUP, 16'h0012, 8'h00);
    // fill the rest of the array
    for (int i = 0; i < 13; i++) begin
      send_request(OP_FILL, addr_t'({8'(8'h10 + i), 8'h00}), frame_t'(8'h80 + i));
    end
    // full array in fifo mode: victim is slot 0, then the duplicate answers
    send_request(OP_FILL, 16'h4000, 8'h11);
    send_request(OP_LOOKUP, 16'h0034, 8'h00);
    // write to an unused register index is ignored, fifo stays in effect
    write_register(1, '1);
    send_request(OP_FILL, 16'h4100, 8'h22);
    // lru with junk in the upper data bits
    write_register(REG_POLICY, '1);
    send_request(OP_FILL, 16'h4200, 8'h33);
  endtask

  // back to back misses age every entry, then lru replaces the oldest
  task automatic run_steady();
    idle_en = 1'b0;
    for (int i = 0; i < STEADY_ITEMS; i++) begin
      send_request(OP_LOOKUP, addr_t'({8'h80, 8'($urandom)}), frame_t'($urandom));
    end
    send_request(OP_LOOKUP, 16'h4000, 8'h00);
    send_request(OP_FILL, 16'h8100, 8'hC3);
    send_request(OP_LOOKUP, 16'h81FF, 8'h00);
    idle_en = 1'b1;
    write_register(REG_POLICY, {APB_DATA_W{1'b0}});
    send_request(OP_FILL, 16'h8200, 8'h3C);
    send_request(OP_LOOKUP, 16'h8201, 8'h00);
  endtask

  task automatic run_random();
    page_t pg;
    op_e   op;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // small pool so lookups hit and fills collide
      foreach (page_pool[i]) page_pool[i] = page_t'($urandom);
      if ($urandom_range(1) == 0) begin
        write_register(1, $urandom);
      end
      write_register(REG_POLICY, {31'($urandom), 1'(phase % 2 == 0)});
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 80) begin
          pg = page_pool[$urandom_range(POOL_SIZE - 1)];
        end else begin
          pg = page_t'($urandom);
        end
        op = ($urandom_range(99) < 30) ? OP_FILL : OP_LOOKUP;
        send_request(op, addr_t'({pg, 8'($urandom)}), frame_t'($urandom));
      end
    end
  endtask

  initial begin
    sb           = new();
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    idle_en      = 1'b1;
    stall_cycles = 0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_steady();
    run_random();

    // drain, then keep clocking the idle pipeline to show stray beats
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_translations.size() == 0) begin
      $display("PASS tlb_lookup_fifo_lru");
    end else begin
      $display("FAIL tlb_lookup_fifo_lru");
    end
    $finish;
  end

endmodule

// ----- tlb_lookup_fifo_lru.f -----
+incdir+hw/rtl
hw/rtl/tlbl_pkg.sv
hw/rtl/tlbl_if.sv
hw/rtl/tlbl_cfg.sv
hw/rtl/tlbl_cam.sv
hw/rtl/tlbl_lru.sv
hw/rtl/tlb_lookup_fifo_lru.sv
tb/tlb_lookup_fifo_lru_tb.sv
